/* hdl/afk_pkg.sv */
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and the CORDIC arctangent table for the arm
// forward kinematics block.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int QDEPTH = 4;
  localparam int ATAN_IW = 5;

  localparam logic [1:0] REG_L1 = 2'd0;
  localparam logic [1:0] REG_L2 = 2'd1;
  localparam logic [1:0] REG_L3 = 2'd2;
  localparam logic [1:0] REG_L4 = 2'd3;

  localparam logic [11:0] L1_RESET = 12'd1224;
  localparam logic [11:0] L2_RESET = 12'd2399;
  localparam logic [11:0] L3_RESET = 12'd2400;
  localparam logic [11:0] L4_RESET = 12'd1480;

  localparam logic signed [33:0] WRAP_PI       = 34'sd843314857;
  localparam logic signed [33:0] WRAP_TWO_PI   = 34'sd1686629713;
  localparam logic signed [33:0] WRAP_THREE_PI = 34'sd2529944570;
  localparam logic signed [33:0] WRAP_FOUR_PI  = 34'sd3373259426;

  localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008218;

  typedef struct packed {
    logic signed [31:0] z;
    logic               flip;
  } angle_t;

  typedef angle_t [3:0] angles_t;

  typedef struct packed {
    logic signed [31:0] cs;
    logic signed [31:0] sn;
  } trig_t;

  typedef trig_t [3:0] trigs_t;

  typedef struct packed {
    logic [11:0] l1;
    logic [11:0] l2;
    logic [11:0] l3;
    logic [11:0] l4;
  } links_t;

  typedef enum logic {
    CS_IDLE,
    CS_RUN
  } cordic_state_t;

  function automatic logic signed [31:0] atan_q28(logic [ATAN_IW-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd210828714;
      5'd1:  v = 32'sd124459457;
      5'd2:  v = 32'sd65760959;
      5'd3:  v = 32'sd33381290;
      5'd4:  v = 32'sd16755422;
      5'd5:  v = 32'sd8385879;
      5'd6:  v = 32'sd4194219;
      5'd7:  v = 32'sd2097109;
      5'd8:  v = 32'sd1048571;
      5'd9:  v = 32'sd524287;
      5'd10: v = 32'sd262144;
      5'd11: v = 32'sd131072;
      5'd12: v = 32'sd65536;
      5'd13: v = 32'sd32768;
      5'd14: v = 32'sd16384;
      5'd15: v = 32'sd8192;
      5'd16: v = 32'sd4096;
      5'd17: v = 32'sd2048;
      5'd18: v = 32'sd1024;
      5'd19: v = 32'sd512;
      5'd20: v = 32'sd256;
      5'd21: v = 32'sd128;
      5'd22: v = 32'sd64;
      5'd23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/arm_forward_kinematics_4dof.sv */
// ----------------------------------------------------------------------------
// arm_forward_kinematics_4dof
// Forward kinematics of a yaw/pitch/pitch/pitch arm: joint angles in, hand
// pose as rotation entries and position out.
//
//   Channel   Handshake          Payload
//   input     start / busy       base_yaw, shoulder_pitch, elbow_pitch,
//                                wrist_pitch
//   result    done (one cycle)   rot_xx .. rot_zz, pos_x, pos_y, pos_z
//   config    cfg_we             cfg_index, cfg_data
//
// A transaction occupies the CORDIC lanes while they iterate one stage per
// cycle, and the lanes take the next one only after its last stage.
// Done follows the front registers, the queue, the CORDIC lanes and afk_post.
// Up to four transactions wait in the front pipeline and queue; busy is high
// while they are all taken. The receiver cannot stall the result.
// Synchronous reset clears control state and loads the link length defaults.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_4dof #(
  parameter int CORDIC_STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] base_yaw,
  input  logic signed [15:0] shoulder_pitch,
  input  logic signed [15:0] elbow_pitch,
  input  logic signed [15:0] wrist_pitch,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output logic               done,
  output logic signed [15:0] rot_xx,
  output logic signed [15:0] rot_xy,
  output logic signed [15:0] rot_xz,
  output logic signed [15:0] rot_yx,
  output logic signed [15:0] rot_yy,
  output logic signed [15:0] rot_yz,
  output logic signed [15:0] rot_zx,
  output logic signed [15:0] rot_zy,
  output logic signed [15:0] rot_zz,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z
);

  afk_pkg::links_t  links;
  logic             push;
  afk_pkg::angles_t push_data;
  logic             pop;
  logic             q_empty;
  afk_pkg::angles_t q_data;
  logic             res_valid;
  afk_pkg::trigs_t  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      links.l1 <= afk_pkg::L1_RESET;
      links.l2 <= afk_pkg::L2_RESET;
      links.l3 <= afk_pkg::L3_RESET;
      links.l4 <= afk_pkg::L4_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afk_pkg::REG_L1: links.l1 <= cfg_data;
        afk_pkg::REG_L2: links.l2 <= cfg_data;
        afk_pkg::REG_L3: links.l3 <= cfg_data;
        afk_pkg::REG_L4: links.l4 <= cfg_data;
        default: ;
      endcase
    end
  end

  afk_front u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .base_yaw       (base_yaw),
    .shoulder_pitch (shoulder_pitch),
    .elbow_pitch    (elbow_pitch),
    .wrist_pitch    (wrist_pitch),
    .pop            (pop),
    .busy           (busy),
    .push           (push),
    .push_data      (push_data)
  );

  afk_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  afk_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  afk_post u_post (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .links     (links),
    .done      (done),
    .rot_xx    (rot_xx),
    .rot_xy    (rot_xy),
    .rot_xz    (rot_xz),
    .rot_yx    (rot_yx),
    .rot_yy    (rot_yy),
    .rot_yz    (rot_yz),
    .rot_zx    (rot_zx),
    .rot_zy    (rot_zy),
    .rot_zz    (rot_zz),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
  );

endmodule

/* hdl/afk_front.sv */
// ----------------------------------------------------------------------------
// afk_front
// Accepts joint angles, forms the pitch sums, wraps each angle into one turn
// and folds it into the right half-plane for the CORDIC lanes.
// ----------------------------------------------------------------------------
module afk_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [15:0]   base_yaw,
  input  logic signed [15:0]   shoulder_pitch,
  input  logic signed [15:0]   elbow_pitch,
  input  logic signed [15:0]   wrist_pitch,
  input  logic                 pop,
  output logic                 busy,
  output logic                 push,
  output afk_pkg::angles_t     push_data
);

  localparam int OW = $clog2(afk_pkg::QDEPTH + 1);

  logic [OW-1:0]      occ;
  logic [OW-1:0]      occ_next;
  logic               accept;
  logic               v1;
  logic               v2;
  logic signed [17:0] ang [4];
  logic signed [33:0] zf [4];
  logic signed [31:0] wrap_z [4];
  logic signed [31:0] wz [4];
  afk_pkg::angles_t   fold;

  assign busy   = (occ == OW'(afk_pkg::QDEPTH));
  assign accept = start & ~busy;

  always_comb begin
    occ_next = occ + OW'(accept) - OW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ  <= '0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      push <= 1'b0;
    end else begin
      occ  <= occ_next;
      v1   <= accept;
      v2   <= v1;
      push <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ang[0] <= 18'(base_yaw);
    ang[1] <= 18'(shoulder_pitch);
    ang[2] <= 18'(shoulder_pitch) + 18'(elbow_pitch);
    ang[3] <= 18'(shoulder_pitch) + 18'(elbow_pitch) + 18'(wrist_pitch);
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      zf[k] = {ang[k][17], ang[k], 15'b0};
      priority if (zf[k] > afk_pkg::WRAP_THREE_PI) begin
        wrap_z[k] = 32'(zf[k] - afk_pkg::WRAP_FOUR_PI);
      end else if (zf[k] > afk_pkg::WRAP_PI) begin
        wrap_z[k] = 32'(zf[k] - afk_pkg::WRAP_TWO_PI);
      end else if (zf[k] < -afk_pkg::WRAP_THREE_PI) begin
        wrap_z[k] = 32'(zf[k] + afk_pkg::WRAP_FOUR_PI);
      end else if (zf[k] < -afk_pkg::WRAP_PI) begin
        wrap_z[k] = 32'(zf[k] + afk_pkg::WRAP_TWO_PI);
      end else begin
        wrap_z[k] = 32'(zf[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      wz[k] <= wrap_z[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      priority if (wz[k] > afk_pkg::Q28_HALF_PI) begin
        fold[k].z    = wz[k] - afk_pkg::Q28_PI;
        fold[k].flip = 1'b1;
      end else if (wz[k] < -afk_pkg::Q28_HALF_PI) begin
        fold[k].z    = wz[k] + afk_pkg::Q28_PI;
        fold[k].flip = 1'b1;
      end else begin
        fold[k].z    = wz[k];
        fold[k].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    push_data <= fold;
  end

endmodule

/* hdl/afk_queue.sv */
// ----------------------------------------------------------------------------
// afk_queue
// Short first-in first-out queue of folded angle sets between the front
// part and the CORDIC engine.
// ----------------------------------------------------------------------------
module afk_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  afk_pkg::angles_t push_data,
  input  logic             pop,
  output logic             empty,
  output afk_pkg::angles_t pop_data
);

  localparam int PW = $clog2(afk_pkg::QDEPTH);
  localparam int CW = $clog2(afk_pkg::QDEPTH + 1);

  afk_pkg::angles_t mem [afk_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/afk_cordic.sv */
// ----------------------------------------------------------------------------
// afk_cordic
// Four rotation-mode CORDIC lanes that iterate one stage per cycle and
// return cosine and sine in Q.28 for each angle of a transaction.
// ----------------------------------------------------------------------------
module afk_cordic #(
  parameter int STAGES = afk_pkg::CORDIC_STAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  afk_pkg::angles_t q_data,
  output logic             pop,
  output logic             res_valid,
  output afk_pkg::trigs_t  res
);

  localparam int IW = (STAGES > 1) ? $clog2(STAGES) : 1;

  afk_pkg::cordic_state_t state;
  afk_pkg::cordic_state_t state_next;
  logic [IW-1:0]          iter;
  logic                   last;
  logic signed [31:0]     x [4];
  logic signed [31:0]     y [4];
  logic signed [31:0]     z [4];
  logic                   flip [4];
  logic signed [31:0]     xn [4];
  logic signed [31:0]     yn [4];
  logic signed [31:0]     zn [4];
  logic signed [31:0]     atan;

  assign last = (iter == IW'(STAGES - 1));
  assign atan = afk_pkg::atan_q28(afk_pkg::ATAN_IW'(iter));

  always_comb begin
    state_next = state;
    unique case (state)
      afk_pkg::CS_IDLE: begin
        if (!q_empty) begin
          state_next = afk_pkg::CS_RUN;
        end
      end
      afk_pkg::CS_RUN: begin
        if (last && q_empty) begin
          state_next = afk_pkg::CS_IDLE;
        end
      end
      default: state_next = afk_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    unique case (state)
      afk_pkg::CS_IDLE: pop = !q_empty;
      afk_pkg::CS_RUN:  pop = last && !q_empty;
      default:          pop = 1'b0;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (z[k] >= 0) begin
        xn[k] = x[k] - (y[k] >>> iter);
        yn[k] = y[k] + (x[k] >>> iter);
        zn[k] = z[k] - atan;
      end else begin
        xn[k] = x[k] + (y[k] >>> iter);
        yn[k] = y[k] - (x[k] >>> iter);
        zn[k] = z[k] + atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= afk_pkg::CS_IDLE;
      iter      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= (state == afk_pkg::CS_RUN) && last;
      if (pop) begin
        iter <= '0;
      end else if (state == afk_pkg::CS_RUN) begin
        iter <= iter + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (pop) begin
        x[k]    <= afk_pkg::CORDIC_GAIN;
        y[k]    <= '0;
        z[k]    <= q_data[k].z;
        flip[k] <= q_data[k].flip;
      end else begin
        x[k] <= xn[k];
        y[k] <= yn[k];
        z[k] <= zn[k];
      end
      if ((state == afk_pkg::CS_RUN) && last) begin
        res[k].cs <= flip[k] ? -xn[k] : xn[k];
        res[k].sn <= flip[k] ? -yn[k] : yn[k];
      end
    end
  end

endmodule

/* hdl/afk_post.sv */
// ----------------------------------------------------------------------------
// afk_post
// Pipeline that turns the four cosine and sine pairs into the rotation
// entries and the hand position, with rounding and saturation.
// ----------------------------------------------------------------------------
module afk_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  afk_pkg::trigs_t    res,
  input  afk_pkg::links_t    links,
  output logic               done,
  output logic signed [15:0] rot_xx,
  output logic signed [15:0] rot_xy,
  output logic signed [15:0] rot_xz,
  output logic signed [15:0] rot_yx,
  output logic signed [15:0] rot_yy,
  output logic signed [15:0] rot_yz,
  output logic signed [15:0] rot_zx,
  output logic signed [15:0] rot_zy,
  output logic signed [15:0] rot_zz,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z
);

  function automatic logic signed [15:0] sat16(logic signed [63:0] v,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    logic signed [15:0] r;
    if (v < lo) begin
      r = 16'(lo);
    end else if (v > hi) begin
      r = 16'(hi);
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  localparam logic signed [63:0] HALF42 = 64'sd1 <<< 41;
  localparam logic signed [63:0] HALF14 = 64'sd1 <<< 13;
  localparam logic signed [63:0] Q14_LO = -64'sd16384;
  localparam logic signed [63:0] Q14_HI = 64'sd16384;
  localparam logic signed [63:0] P_LO   = -64'sd32768;
  localparam logic signed [63:0] P_HI   = 64'sd32767;

  logic               v1;
  logic               v2;
  logic               v3;
  logic signed [63:0] m_cc;
  logic signed [63:0] m_cs;
  logic signed [63:0] m_sc;
  logic signed [63:0] m_ss;
  logic signed [44:0] lr [3];
  logic signed [44:0] lh [3];
  logic signed [31:0] c0_1;
  logic signed [31:0] s0_1;
  logic signed [31:0] cc_1;
  logic signed [31:0] sc_1;
  logic signed [31:0] c0_2;
  logic signed [31:0] s0_2;
  logic signed [31:0] rq;
  logic signed [19:0] hz_2;
  logic signed [19:0] hz_3;
  logic signed [15:0] rot2 [8];
  logic signed [15:0] rot3 [8];
  logic signed [46:0] reach;
  logic signed [46:0] height;
  logic signed [46:0] rq_full;
  logic signed [46:0] hz_full;
  logic signed [63:0] mx;
  logic signed [63:0] my;
  logic signed [63:0] pz_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= res_valid;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    m_cc  <= 64'(res[0].cs) * 64'(res[3].cs);
    m_cs  <= 64'(res[0].cs) * 64'(res[3].sn);
    m_sc  <= 64'(res[0].sn) * 64'(res[3].cs);
    m_ss  <= 64'(res[0].sn) * 64'(res[3].sn);
    lr[0] <= 45'($signed({1'b0, links.l2})) * 45'(res[1].sn);
    lr[1] <= 45'($signed({1'b0, links.l3})) * 45'(res[2].sn);
    lr[2] <= 45'($signed({1'b0, links.l4})) * 45'(res[3].sn);
    lh[0] <= 45'($signed({1'b0, links.l2})) * 45'(res[1].cs);
    lh[1] <= 45'($signed({1'b0, links.l3})) * 45'(res[2].cs);
    lh[2] <= 45'($signed({1'b0, links.l4})) * 45'(res[3].cs);
    c0_1  <= res[0].cs;
    s0_1  <= res[0].sn;
    cc_1  <= res[3].cs;
    sc_1  <= res[3].sn;
  end

  always_comb begin
    reach   = 47'(lr[0]) + 47'(lr[1]) + 47'(lr[2]);
    height  = 47'(lh[0]) + 47'(lh[1]) + 47'(lh[2]);
    rq_full = (reach + 47'(HALF14)) >>> 14;
    hz_full = (height + (47'sd1 <<< 27)) >>> 28;
  end

  always_ff @(posedge clk) begin
    rot2[0] <= sat16((m_cc + HALF42) >>> 42, Q14_LO, Q14_HI);
    rot2[1] <= -sat16((64'(s0_1) + HALF14) >>> 14, Q14_LO, Q14_HI);
    rot2[2] <= sat16((m_cs + HALF42) >>> 42, Q14_LO, Q14_HI);
    rot2[3] <= sat16((m_sc + HALF42) >>> 42, Q14_LO, Q14_HI);
    rot2[4] <= sat16((64'(c0_1) + HALF14) >>> 14, Q14_LO, Q14_HI);
    rot2[5] <= sat16((m_ss + HALF42) >>> 42, Q14_LO, Q14_HI);
    rot2[6] <= -sat16((64'(sc_1) + HALF14) >>> 14, Q14_LO, Q14_HI);
    rot2[7] <= sat16((64'(cc_1) + HALF14) >>> 14, Q14_LO, Q14_HI);
    rq      <= 32'(rq_full);
    hz_2    <= 20'(hz_full);
    c0_2    <= c0_1;
    s0_2    <= s0_1;
  end

  always_ff @(posedge clk) begin
    mx   <= 64'(c0_2) * 64'(rq);
    my   <= 64'(s0_2) * 64'(rq);
    hz_3 <= hz_2;
    for (int k = 0; k < 8; k++) begin
      rot3[k] <= rot2[k];
    end
  end

  always_comb begin
    pz_full = 64'($signed({1'b0, links.l1})) + 64'(hz_3);
  end

  always_ff @(posedge clk) begin
    rot_xx <= rot3[0];
    rot_xy <= rot3[1];
    rot_xz <= rot3[2];
    rot_yx <= rot3[3];
    rot_yy <= rot3[4];
    rot_yz <= rot3[5];
    rot_zx <= rot3[6];
    rot_zz <= rot3[7];
    pos_x  <= sat16((mx + HALF42) >>> 42, P_LO, P_HI);
    pos_y  <= sat16((my + HALF42) >>> 42, P_LO, P_HI);
    pos_z  <= sat16(pz_full, P_LO, P_HI);
  end

  assign rot_zy = 16'sd0;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the four-joint arm forward kinematics block.
// A directed table covers zero pose, angle extremes and wrapping sums, then
// random poses run under several link length settings. Each pose but the
// zero pose is predicted in fixed point; done strobes are compared by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int STAGES = afk_pkg::CORDIC_STAGES_DEF;
  localparam int LIMIT = 400000;
  localparam longint PI_Q = 843314857;
  localparam longint TWO_PI_Q = 1686629713;
  localparam longint HALF_PI_Q = 421657428;
  localparam longint GAIN_Q = 163008218;
  localparam logic signed [15:0] AMAX = 16'sd25736;
  localparam logic signed [15:0] AMIN = -16'sd25736;
  localparam logic signed [15:0] AHALF = 16'sd12868;

  typedef logic [11:0][15:0] pose_t;

  typedef struct {
    logic signed [15:0] j[4];
    bit typed;
    pose_t pose;
  } row_t;

  localparam longint ARCTAN [16] = '{210828714, 124459457, 65760959, 33381290,
    16755422, 8385879, 4194219, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192};

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic signed [15:0] base_yaw = 0, shoulder_pitch = 0, elbow_pitch = 0, wrist_pitch = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = afk_pkg::REG_L1;
  logic [11:0] cfg_data = 0;
  logic busy, done;
  logic signed [15:0] rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz;
  logic signed [15:0] rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z;

  logic [11:0] link [4];
  pose_t pending_poses [$];
  int fails = 0;
  int cycles = 0;
  bit quiet = 0;

  arm_forward_kinematics_4dof dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void sincos(longint ang, output longint cs, output longint sn);
    longint z, x, y, t;
    bit flip;
    z = ang * 32768;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    while (z > PI_Q) z -= TWO_PI_Q;
    while (z < -PI_Q) z += TWO_PI_Q;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = t;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic pose_t hand_pose(logic signed [15:0] j[4]);
    longint a, b, c, c0, s0, ca, sa, cb, sb, cc, sc, reach, height, rq;
    longint r [12];
    pose_t p;
    a = longint'(j[1]);
    b = a + longint'(j[2]);
    c = b + longint'(j[3]);
    sincos(longint'(j[0]), c0, s0);
    sincos(a, ca, sa);
    sincos(b, cb, sb);
    sincos(c, cc, sc);
    r[0] = clip(rnd(c0 * cc, 42), -16384, 16384);
    r[1] = -clip(rnd(s0, 14), -16384, 16384);
    r[2] = clip(rnd(c0 * sc, 42), -16384, 16384);
    r[3] = clip(rnd(s0 * cc, 42), -16384, 16384);
    r[4] = clip(rnd(c0, 14), -16384, 16384);
    r[5] = clip(rnd(s0 * sc, 42), -16384, 16384);
    r[6] = -clip(rnd(sc, 14), -16384, 16384);
    r[7] = 0;
    r[8] = clip(rnd(cc, 14), -16384, 16384);
    reach = longint'(link[1]) * sa + longint'(link[2]) * sb + longint'(link[3]) * sc;
    height = longint'(link[1]) * ca + longint'(link[2]) * cb + longint'(link[3]) * cc;
    rq = rnd(reach, 14);
    r[9] = clip(rnd(c0 * rq, 42), -32768, 32767);
    r[10] = clip(rnd(s0 * rq, 42), -32768, 32767);
    r[11] = clip(longint'(link[0]) + rnd(height, 28), -32768, 32767);
    for (int k = 0; k < 12; k++) p[k] = r[k][15:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && done) begin
      got = {pos_z, pos_y, pos_x, rot_zz, rot_zy, rot_zx, rot_yz, rot_yy, rot_yx,
             rot_xz, rot_xy, rot_xx};
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fails++;
      end else begin
        want = pending_poses.pop_front();
        for (int k = 0; k < 12; k++)
          if (got[k] !== want[k]) begin
            $display("%0t: field %0d expected %0d actual %0d", $time, k,
                     $signed(want[k]), $signed(got[k]));
            fails++;
          end
      end
    end
  end

  task automatic send_pose(logic signed [15:0] j[4], bit typed, pose_t typed_pose);
    if (!quiet && $urandom_range(0, 99) < 8) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1;
    base_yaw <= j[0];
    shoulder_pitch <= j[1];
    elbow_pitch <= j[2];
    wrist_pitch <= j[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_poses.insert(pending_poses.size(), typed ? typed_pose : hand_pose(j));
  endtask

  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (STAGES + 20) @(posedge clk);
  endtask

  task automatic set_links(logic [11:0] l0, logic [11:0] l1, logic [11:0] l2, logic [11:0] l3);
    logic [11:0] v [4];
    v = '{l0, l1, l2, l3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_data <= v[i];
      link[i] = v[i];
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return AMAX;
      1: return AMIN;
      default: return 16'($signed($urandom_range(0, 51472)) - 25736);
    endcase
  endfunction

  initial begin
    row_t rows [$];
    row_t rw;
    logic signed [15:0] j [4];
    link = '{afk_pkg::L1_RESET, afk_pkg::L2_RESET, afk_pkg::L3_RESET, afk_pkg::L4_RESET};
    rw.typed = 1;
    rw.j = '{0, 0, 0, 0};
    rw.pose = {16'sd7503, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384,
               16'sd0, 16'sd0, 16'sd0, 16'sd16384};
    rows.insert(rows.size(), rw);
    rw.typed = 0;
    rw.pose = '0;
    rw.j = '{AMAX, AMAX, AMAX, AMAX};
    rows.insert(rows.size(), rw);
    rw.j = '{AMIN, AMIN, AMIN, AMIN};
    rows.insert(rows.size(), rw);
    rw.j = '{AMAX, AMIN, AMAX, AMIN};
    rows.insert(rows.size(), rw);
    rw.j = '{AHALF, AHALF, 0, 0};
    rows.insert(rows.size(), rw);
    rw.j = '{-AHALF, -AHALF, -AHALF, 0};
    rows.insert(rows.size(), rw);
    rw.j = '{16'sd12869, 16'sd12869, 16'sd12869, 16'sd12869};
    rows.insert(rows.size(), rw);
    rw.j = '{16'sd25735, 16'sd25000, 16'sd25000, 16'sd25000};
    rows.insert(rows.size(), rw);
    rw.j = '{16'sd1, -16'sd1, 16'sd1, -16'sd1};
    rows.insert(rows.size(), rw);
    rw.j = '{16'sd6434, 16'sd6434, 16'sd6434, 16'sd6434};
    rows.insert(rows.size(), rw);
    rw.j = '{-16'sd19302, 16'sd19302, -16'sd19302, 16'sd19302};
    rows.insert(rows.size(), rw);

    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) send_pose(rows[i].j, rows[i].typed, rows[i].pose);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_links(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        1: set_links(12'd0, 12'd0, 12'd0, 12'd0);
        default: set_links(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                           12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      quiet = (ph == 2);
      if (ph == 0) begin
        send_pose('{0, AHALF, 0, 0}, 0, '0);
        send_pose('{AMAX, AHALF, 0, 0}, 0, '0);
      end
      for (int n = 0; n < 100; n++) begin
        for (int k = 0; k < 4; k++) j[k] = rand_angle();
        send_pose(j, 0, '0);
        if (ph == 3 && n == 50) begin
          start <= 0;
          @(posedge clk);
          while (pending_poses.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
